/* hw/rtl/usbhps_pkg.sv */
// usbhps_pkg: shared types and codes for the usb hub port status unit
// no dependencies; imported by every module under hw/rtl
package usbhps_pkg;

  localparam int PORT_COUNT = 6;
  localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int BITMAP_W   = 7;

  // request codes
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_CLR  = 2'd1;
  localparam logic [1:0] CMD_GET  = 2'd2;
  localparam logic [1:0] CMD_POLL = 2'd3;

  localparam logic [1:0] RCP_HUB  = 2'd0;
  localparam logic [1:0] RCP_PORT = 2'd3;

  // hub feature selectors
  localparam logic [15:0] HUB_FEAT_LOCAL_POWER  = 16'd0;
  localparam logic [15:0] HUB_FEAT_OVER_CURRENT = 16'd1;

  // port feature selectors
  localparam logic [15:0] PORT_FEAT_ENABLE    = 16'd1;
  localparam logic [15:0] PORT_FEAT_SUSPEND   = 16'd2;
  localparam logic [15:0] PORT_FEAT_RESET     = 16'd4;
  localparam logic [15:0] PORT_FEAT_POWER     = 16'd8;
  localparam logic [15:0] PORT_FEAT_LOW_SPEED = 16'd9;
  localparam logic [15:0] PORT_FEAT_C_FIRST   = 16'd16;
  localparam logic [15:0] PORT_FEAT_C_LAST    = 16'd22;

  localparam logic [15:0] CONNECT_AFTER_POLLS_RESET = 16'd20;
  localparam logic [15:0] POLL_COUNT_MAX            = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  recipient;
    logic [15:0] port_index;
    logic [15:0] feature_selector;
  } req_t;

  typedef struct packed {
    logic                result_code;
    logic [15:0]         port_status_word;
    logic [15:0]         port_change_word;
    logic [BITMAP_W-1:0] change_bitmap;
  } rsp_t;

  typedef struct packed {
    logic c_rst;
    logic c_susp;
    logic c_ena;
    logic c_conn;
    logic high;
    logic low;
    logic pwr;
    logic rst;
    logic susp;
    logic ena;
    logic conn;
  } port_flags_t;

endpackage

/* hw/rtl/usb_hub_port_status_unit.sv */
// usb_hub_port_status_unit: top level of the emulated hub port status block
// depends on usbhps_pkg, usbhps_req_stage and usbhps_port_update
//
//   channel   handshake            payload             notes
//   request   start & !busy        req  (req_t)        busy is never raised
//   result    done, one cycle      rsp  (rsp_t)        receiver cannot stall
//   config    cfg_we               cfg_data (16 bit)   connect_after_polls
//
// an item is registered into req_q at the accept edge, then resolved into the
// result register rsp together with done, so done is high in the cycle after
// req_valid and the result is taken while done is high
// one item per cycle sustained: the flags and poll counter update in the
// same cycle the result is registered, ready for the next item
// synchronous reset clears flags, poll count, threshold (to 20) and strobes
module usb_hub_port_status_unit
  import usbhps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  // request stage
  logic req_valid;
  req_t req_q;

  // architectural state
  port_flags_t port_flags      [PORT_COUNT];
  port_flags_t port_flags_next [PORT_COUNT];
  logic [15:0] poll_count;
  logic [15:0] poll_count_next;
  logic [15:0] connect_after_polls;

  // decode of the registered item
  logic                  port_ok;
  logic [PORT_IDX_W-1:0] port_sel;
  port_flags_t           upd_flags;
  logic                  upd_ok;
  logic [15:0]           upd_status;
  logic [15:0]           upd_change;
  logic                  ok;
  rsp_t                  rsp_next;

  // the block can take an item in every cycle
  assign busy = 1'b0;

  usbhps_req_stage u_req_stage (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .req_valid (req_valid),
    .req_q     (req_q)
  );

  // one-based port number, only in range 1..PORT_COUNT
  assign port_ok  = (req_q.port_index != 16'd0) &&
                    (req_q.port_index <= 16'(PORT_COUNT));
  assign port_sel = port_ok ? PORT_IDX_W'(req_q.port_index - 16'd1) : '0;

  usbhps_port_update u_port_update (
    .flags       (port_flags[port_sel]),
    .cmd         (req_q.cmd),
    .sel         (req_q.feature_selector),
    .flags_next  (upd_flags),
    .ok          (upd_ok),
    .status_word (upd_status),
    .change_word (upd_change)
  );

  always_comb begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      port_flags_next[i] = port_flags[i];
    end
    poll_count_next = poll_count;
    ok              = 1'b0;
    rsp_next        = '0;

    if (req_valid) begin
      if (req_q.cmd == CMD_POLL) begin
        // saturating poll counter; a held count never re-triggers connect
        if (poll_count != POLL_COUNT_MAX) begin
          poll_count_next = poll_count + 16'd1;
          if (poll_count_next == connect_after_polls) begin
            port_flags_next[0].conn   = 1'b1;
            port_flags_next[0].c_conn = 1'b1;
          end
        end
        ok = 1'b1;
        // bitmap reflects the flags after this poll's connect event
        for (int i = 0; i < PORT_COUNT; i++) begin
          if (i < BITMAP_W - 1) begin
            rsp_next.change_bitmap[i+1] = port_flags_next[i].c_conn |
                                          port_flags_next[i].c_ena |
                                          port_flags_next[i].c_susp |
                                          port_flags_next[i].c_rst;
          end
        end
      end else if (req_q.recipient == RCP_HUB) begin
        // hub device: get status reads zero, set/clear only the two hub features
        ok = (req_q.cmd == CMD_GET) ||
             (req_q.feature_selector == HUB_FEAT_LOCAL_POWER) ||
             (req_q.feature_selector == HUB_FEAT_OVER_CURRENT);
      end else if ((req_q.recipient == RCP_PORT) && port_ok) begin
        ok = upd_ok;
        if (upd_ok) begin
          port_flags_next[port_sel] = upd_flags;
          if (req_q.cmd == CMD_GET) begin
            rsp_next.port_status_word = upd_status;
            rsp_next.port_change_word = upd_change;
          end
        end
      end
    end
    rsp_next.result_code = ~ok;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        port_flags[i] <= '0;
      end
      poll_count <= '0;
    end else begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        port_flags[i] <= port_flags_next[i];
      end
      poll_count <= poll_count_next;
    end
  end

  // configuration register, to be written by the user only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      connect_after_polls <= CONNECT_AFTER_POLLS_RESET;
    end else if (cfg_we) begin
      connect_after_polls <= cfg_data;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  logic [PORT_COUNT-1:0] rst_bits;

  always_comb begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      rst_bits[i] = port_flags[i].rst;
    end
  end

  // every registered item yields exactly one result on the next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    req_valid |=> done)
    else $error("registered item did not produce a result");

  // a result strobe always follows a registered item
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_valid))
    else $error("result strobe without an item");

  // rejected items carry all-zero words
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.result_code) |->
      (rsp.port_status_word == 16'd0 && rsp.port_change_word == 16'd0 &&
       rsp.change_bitmap == '0))
    else $error("rejected item carries nonzero words");

  // port reset completes at once, so no reset status bit ever sticks
  a_no_reset_bit: assert property (@(posedge clk) disable iff (rst)
    rst_bits == '0)
    else $error("port reset status bit set");

  // the poll counter never moves backward outside reset
  a_poll_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> poll_count >= $past(poll_count))
    else $error("poll counter decreased");
`endif

endmodule

/* hw/rtl/usbhps_req_stage.sv */
// usbhps_req_stage: input register for one request item
// depends on usbhps_pkg
module usbhps_req_stage
  import usbhps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  output logic req_valid,
  output req_t req_q
);

  logic accept;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

endmodule

/* hw/rtl/usbhps_port_update.sv */
// usbhps_port_update: per-port request decode, next flags and status words
// depends on usbhps_pkg
module usbhps_port_update
  import usbhps_pkg::*;
(
  input  port_flags_t flags,
  input  logic [1:0]  cmd,
  input  logic [15:0] sel,
  output port_flags_t flags_next,
  output logic        ok,
  output logic [15:0] status_word,
  output logic [15:0] change_word
);

  logic is_set;

  assign is_set = (cmd == CMD_SET);

  assign status_word = {5'b0, flags.high, flags.low, flags.pwr, 3'b0, flags.rst, 1'b0,
                        flags.susp, flags.ena, flags.conn};
  assign change_word = {11'b0, flags.c_rst, 1'b0, flags.c_susp, flags.c_ena, flags.c_conn};

  always_comb begin
    flags_next = flags;
    ok         = 1'b1;
    if (cmd == CMD_GET) begin
      // get status clears the change bits
      flags_next.c_conn = 1'b0;
      flags_next.c_ena  = 1'b0;
      flags_next.c_susp = 1'b0;
      flags_next.c_rst  = 1'b0;
    end else begin
      unique case (sel) inside
        PORT_FEAT_ENABLE: begin
          if (is_set != flags.ena) flags_next.c_ena = 1'b1;
          flags_next.ena = is_set;
        end
        PORT_FEAT_SUSPEND: begin
          if (is_set != flags.susp) flags_next.c_susp = 1'b1;
          flags_next.susp = is_set;
        end
        PORT_FEAT_RESET: begin
          // reset completes at once, so the reset bit itself stays low
          if (is_set != flags.rst) flags_next.c_rst = 1'b1;
          if (is_set) flags_next.ena = 1'b1;
        end
        PORT_FEAT_POWER: begin
          flags_next.pwr = is_set;
        end
        PORT_FEAT_LOW_SPEED: begin
          flags_next.low  = is_set;
          flags_next.high = ~is_set;
        end
        [PORT_FEAT_C_FIRST:PORT_FEAT_C_LAST]: begin
          flags_next = flags;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

endmodule

/* verif/tb_usb_hub_port_status_unit.sv */
// tb_usb_hub_port_status_unit: self-checking testbench for the hub port status unit
// drives requests, predicts responses with its own port flag model, checks them
// depends on usbhps_pkg and usb_hub_port_status_unit
`timescale 1ns / 1ps

module tb_usb_hub_port_status_unit;
  import usbhps_pkg::*;

  // port selectors that the package leaves unnamed, both rejected by port set and clear
  localparam logic [15:0] PORT_FEAT_CONNECTION   = 16'd0;
  localparam logic [15:0] PORT_FEAT_OVER_CURRENT = 16'd3;

  // settle time after the last response
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_PERCENT = 36;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  usb_hub_port_status_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // requests waiting to go out, and responses the model says must come back
  req_t requests_to_send[$];
  rsp_t responses_due[$];

  // model state: per-port flags, saturating poll counter, connect threshold
  port_flags_t port_state [PORT_COUNT];
  logic [15:0] polls_seen = '0;
  logic [15:0] connect_threshold = CONNECT_AFTER_POLLS_RESET;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      port_state[i] = '0;
    end
  end

  // work out the response to one accepted request and update the model
  task automatic resolve_request(input req_t r);
    rsp_t        o;
    port_flags_t f;
    logic        ok;
    logic        port_ok;
    logic        set_op;
    int          p;
    o = '0;
    ok = 1'b0;
    set_op = (r.cmd == CMD_SET);
    port_ok = (r.port_index >= 16'd1) && (r.port_index <= PORT_COUNT);
    p = port_ok ? int'(r.port_index) - 1 : 0;
    if (r.cmd == CMD_POLL) begin
      // poll ignores every other field and always succeeds
      if (polls_seen != POLL_COUNT_MAX) begin
        polls_seen = polls_seen + 16'd1;
        // a held, saturated count never fires the connection again
        if (polls_seen == connect_threshold) begin
          port_state[0].conn = 1'b1;
          port_state[0].c_conn = 1'b1;
        end
      end
      for (int i = 0; i < PORT_COUNT && i < BITMAP_W - 1; i++) begin
        if (|{port_state[i].c_rst, port_state[i].c_susp, port_state[i].c_ena,
              port_state[i].c_conn})
          o.change_bitmap[i+1] = 1'b1;
      end
      ok = 1'b1;
    end else if (r.recipient == RCP_HUB) begin
      // hub get status returns zero words; only local power and over-current
      // selectors are accepted for set and clear, and they do nothing
      ok = (r.cmd == CMD_GET) ||
           (r.feature_selector == HUB_FEAT_LOCAL_POWER) ||
           (r.feature_selector == HUB_FEAT_OVER_CURRENT);
    end else if (r.recipient == RCP_PORT && port_ok) begin
      f = port_state[p];
      if (r.cmd == CMD_GET) begin
        o.port_status_word = {5'b0, f.high, f.low, f.pwr, 3'b0, f.rst, 1'b0,
                              f.susp, f.ena, f.conn};
        o.port_change_word = {11'b0, f.c_rst, 1'b0, f.c_susp, f.c_ena, f.c_conn};
        // reading the status acknowledges every change bit of that port
        f.c_conn = 1'b0;
        f.c_ena = 1'b0;
        f.c_susp = 1'b0;
        f.c_rst = 1'b0;
        ok = 1'b1;
      end else begin
        ok = 1'b1;
        case (r.feature_selector)
          PORT_FEAT_ENABLE: begin
            if (f.ena != set_op) f.c_ena = 1'b1;
            f.ena = set_op;
          end
          PORT_FEAT_SUSPEND: begin
            if (f.susp != set_op) f.c_susp = 1'b1;
            f.susp = set_op;
          end
          PORT_FEAT_RESET: begin
            // reset completes at once: enable plus a reset change, and the
            // reset bit itself is never left set
            if (set_op) begin
              if (!f.rst) f.c_rst = 1'b1;
              f.ena = 1'b1;
            end else if (f.rst) begin
              f.c_rst = 1'b1;
            end
          end
          PORT_FEAT_POWER: begin
            f.pwr = set_op;
          end
          PORT_FEAT_LOW_SPEED: begin
            // clearing low speed selects high speed
            f.low = set_op;
            f.high = !set_op;
          end
          default: begin
            // change-clear selectors are accepted as no-ops, the rest stall
            ok = (r.feature_selector >= PORT_FEAT_C_FIRST) &&
                 (r.feature_selector <= PORT_FEAT_C_LAST);
          end
        endcase
      end
      if (ok) port_state[p] = f;
    end
    // a rejected request carries all-zero words
    o.result_code = !ok;
    responses_due.push_back(o);
  endtask

  function automatic req_t mk_req(input logic [1:0] c, input logic [1:0] rc,
                                  input logic [15:0] pi, input logic [15:0] fs);
    req_t r;
    r.cmd = c;
    r.recipient = rc;
    r.port_index = pi;
    r.feature_selector = fs;
    return r;
  endfunction

  // mostly well-formed port traffic, with some hub requests and some noise
  function automatic req_t random_request();
    req_t r;
    int   k;
    k = $urandom_range(99);
    if (k < 30) r.cmd = CMD_SET;
    else if (k < 50) r.cmd = CMD_CLR;
    else if (k < 75) r.cmd = CMD_GET;
    else r.cmd = CMD_POLL;
    k = $urandom_range(99);
    if (k < 80) r.recipient = RCP_PORT;
    else if (k < 90) r.recipient = RCP_HUB;
    else r.recipient = 2'($urandom_range(1, 2));
    k = $urandom_range(99);
    if (k < 85) r.port_index = 16'($urandom_range(1, PORT_COUNT));
    else if (k < 90) r.port_index = 16'd0;
    else if (k < 94) r.port_index = 16'(PORT_COUNT + 1);
    else r.port_index = 16'($urandom);
    k = $urandom_range(99);
    if (k < 82) begin
      case ($urandom_range(7))
        0: r.feature_selector = PORT_FEAT_ENABLE;
        1: r.feature_selector = PORT_FEAT_SUSPEND;
        2: r.feature_selector = PORT_FEAT_RESET;
        3: r.feature_selector = PORT_FEAT_POWER;
        4: r.feature_selector = PORT_FEAT_LOW_SPEED;
        5: r.feature_selector = PORT_FEAT_CONNECTION;
        6: r.feature_selector = PORT_FEAT_OVER_CURRENT;
        default: r.feature_selector = 16'($urandom_range(PORT_FEAT_C_FIRST,
                                                        PORT_FEAT_C_LAST));
      endcase
    end else begin
      r.feature_selector = 16'($urandom);
    end
    return r;
  endfunction

  // request driver: start held until accepted, random idle gaps between
  // items, except inside a recurring quiet window where it streams
  always @(posedge clk) begin
    logic calm;
    logic idle_now;
    cycle_count <= cycle_count + 1;
    calm = (cycle_count % 900) >= 700;
    idle_now = !calm && ($urandom_range(99) < IDLE_PERCENT);
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        resolve_request(req);
      end
      // only one nonblocking write of start per edge
      if (!start || !busy) begin
        if (requests_to_send.size() > 0 && !idle_now) begin
          start <= 1'b1;
          req <= requests_to_send.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // response monitor: every done cycle is checked against the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (responses_due.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %h", $time, rsp);
        mismatches++;
      end else begin
        want = responses_due.pop_front();
        report_field("result_code", 16'(want.result_code), 16'(rsp.result_code));
        report_field("port_status_word", want.port_status_word, rsp.port_status_word);
        report_field("port_change_word", want.port_change_word, rsp.port_change_word);
        report_field("change_bitmap", 16'(want.change_bitmap), 16'(rsp.change_bitmap));
      end
    end
  end

  // wait until every request has gone out and every response has come back
  task automatic wait_drained();
    while (!(requests_to_send.size() == 0 && !start && responses_due.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // threshold writes happen only while the unit is drained
  task automatic write_threshold(input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    connect_threshold = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      requests_to_send.push_back(random_request());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass at the reset threshold: hub requests, bad recipients and
    // ports, every named port selector, then reads of what they changed
    requests_to_send.push_back(mk_req(CMD_GET, RCP_HUB, 16'd0, 16'd0));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_HUB, 16'd0, HUB_FEAT_LOCAL_POWER));
    requests_to_send.push_back(mk_req(CMD_CLR, RCP_HUB, 16'd1, HUB_FEAT_OVER_CURRENT));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_HUB, 16'd1, 16'd2));
    requests_to_send.push_back(mk_req(CMD_GET, 2'd1, 16'd1, 16'd0));
    requests_to_send.push_back(mk_req(CMD_SET, 2'd2, 16'd2, PORT_FEAT_ENABLE));
    requests_to_send.push_back(mk_req(CMD_GET, RCP_PORT, 16'd0, 16'd0));
    requests_to_send.push_back(mk_req(CMD_GET, RCP_PORT, 16'(PORT_COUNT + 1), 16'd0));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'hFFFF, PORT_FEAT_POWER));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd1, PORT_FEAT_CONNECTION));
    requests_to_send.push_back(mk_req(CMD_CLR, RCP_PORT, 16'd1, PORT_FEAT_OVER_CURRENT));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'(PORT_COUNT), PORT_FEAT_POWER));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd2, PORT_FEAT_ENABLE));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd2, PORT_FEAT_SUSPEND));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd3, PORT_FEAT_RESET));
    requests_to_send.push_back(mk_req(CMD_CLR, RCP_PORT, 16'd3, PORT_FEAT_RESET));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd4, PORT_FEAT_LOW_SPEED));
    requests_to_send.push_back(mk_req(CMD_CLR, RCP_PORT, 16'd5, PORT_FEAT_LOW_SPEED));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd5, PORT_FEAT_C_FIRST));
    requests_to_send.push_back(mk_req(CMD_CLR, RCP_PORT, 16'd4, PORT_FEAT_C_LAST));
    requests_to_send.push_back(mk_req(CMD_SET, RCP_PORT, 16'd4, 16'hFFFF));
    requests_to_send.push_back(mk_req(CMD_POLL, 2'd3, 16'hFFFF, 16'hFFFF));
    requests_to_send.push_back(mk_req(CMD_GET, RCP_PORT, 16'd2, 16'd0));
    requests_to_send.push_back(mk_req(CMD_GET, RCP_PORT, 16'd3, 16'd0));
    requests_to_send.push_back(mk_req(CMD_POLL, 2'd0, 16'd0, 16'd0));
    // random traffic still at the reset threshold, so port 1 connects at 20
    queue_random(400);
    wait_drained();

    // thresholds just ahead of the current count so each phase sees a
    // connection, plus the minimum, which is already behind the count
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 2) write_threshold(16'd1);
      else write_threshold(polls_seen + 16'($urandom_range(1, 60)));
      queue_random(300);
      wait_drained();
    end

    // maximum threshold, far beyond the count: no further connection event
    write_threshold(16'hFFFF);
    requests_to_send.push_back(mk_req(CMD_GET, RCP_PORT, 16'd1, 16'd0));
    for (int i = 0; i < 20; i++) begin
      requests_to_send.push_back(mk_req(CMD_POLL, 2'($urandom), 16'($urandom),
                                        16'($urandom)));
    end
    requests_to_send.push_back(mk_req(CMD_GET, RCP_PORT, 16'd1, 16'd0));
    queue_random(50);
    wait_drained();

    if (mismatches == 0 && responses_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit: far beyond the slowest legal run
  initial begin
    #100_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* usb_hub_port_status_unit.f */
hw/rtl/usbhps_pkg.sv
hw/rtl/usbhps_req_stage.sv
hw/rtl/usbhps_port_update.sv
hw/rtl/usb_hub_port_status_unit.sv
verif/tb_usb_hub_port_status_unit.sv
